### rtl/apq_pkg.sv
// Shared constants for the array-based minimum priority queue.
package apq_pkg;

   // Field widths of one item.
   localparam int VALUE_W  = 32;
   localparam int RANK_W   = 16;
   localparam int STATUS_W = 2;
   localparam int FILL_W   = 5;
   localparam int ENTRY_W  = VALUE_W + RANK_W;

   // Packed stream widths, padded to whole bytes.
   localparam int REQ_TDATA_W = 48;
   localparam int RSP_PAD_W   = 3;
   localparam int RSP_TDATA_W = VALUE_W + RANK_W + FILL_W + RSP_PAD_W;

   // Request command codes.
   localparam logic CMD_ENQUEUE = 1'b0;
   localparam logic CMD_DEQUEUE = 1'b1;

   // Result status codes.
   localparam logic [STATUS_W-1:0] STATUS_ENQUEUED = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_DEQUEUED = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY    = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd3;

endpackage

### rtl/apq_ram.sv
// Simple dual-port RAM: one write port, one read port with registered data.
module apq_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/array_min_priority_queue.sv
// Channel | Direction | Ports      | Contents (lowest bit first)
// req     | in        | req_t*     | tuser: command; tdata: item_value, item_rank
// rsp     | out       | rsp_t*     | tuser: status; tdata: removed_value, removed_rank,
//         |           |            |        fill_level, zero pad
//
// An enqueue, or a dequeue from an empty queue, holds the block from idle into the finish
// state, where its result is registered once the output register is free.
// A dequeue holds it while it scans every held entry through the single read port, then
// moves each later entry down one place, then registers its result in the finish state.
// Reset is synchronous and empties the queue; the store itself is not cleared.
// A new item is taken only while idle; a result waiting on rsp_tready stalls the last step.
module array_min_priority_queue #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // [31:0] item_value, [47:32] item_rank
   input  logic [apq_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // [0] command
   input  logic [0:0]                       req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [31:0] removed_value, [47:32] removed_rank, [52:48] fill_level, [55:53] zero
   output logic [apq_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   // [1:0] status
   output logic [apq_pkg::STATUS_W-1:0]     rsp_tuser
);

   localparam int IDX_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_SHIFT,
      S_FINISH
   } state_type;

   state_type state_ff, state_in;

   logic [CNT_W-1:0]                 occ_ff, occ_in;
   logic [CNT_W-1:0]                 addr_ff, addr_in;
   logic                             pend_ff, pend_in;
   logic [IDX_W-1:0]                 pend_idx_ff, pend_idx_in;
   logic [IDX_W-1:0]                 best_idx_ff, best_idx_in;
   logic [apq_pkg::VALUE_W-1:0]      best_value_ff, best_value_in;
   logic [apq_pkg::RANK_W-1:0]       best_rank_ff, best_rank_in;
   logic [apq_pkg::STATUS_W-1:0]     res_status_ff, res_status_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [apq_pkg::STATUS_W-1:0]     rsp_status_ff, rsp_status_in;
   logic [apq_pkg::VALUE_W-1:0]      rsp_value_ff, rsp_value_in;
   logic [apq_pkg::RANK_W-1:0]       rsp_rank_ff, rsp_rank_in;
   logic [apq_pkg::FILL_W-1:0]       rsp_fill_ff, rsp_fill_in;

   logic                             wr_en;
   logic [IDX_W-1:0]                 wr_addr;
   logic [apq_pkg::ENTRY_W-1:0]      wr_data;
   logic                             rd_en;
   logic [IDX_W-1:0]                 rd_addr;
   logic [apq_pkg::ENTRY_W-1:0]      rd_data;

   logic                             req_accept;
   logic                             in_cmd;
   logic [apq_pkg::VALUE_W-1:0]      in_value;
   logic [apq_pkg::RANK_W-1:0]       in_rank;
   logic [apq_pkg::VALUE_W-1:0]      rd_value;
   logic [apq_pkg::RANK_W-1:0]       rd_rank;
   logic                             rank_less;
   logic                             take_new;
   logic                             issue;
   logic                             out_free;

   // Entry store: rank in the upper bits, value in the lower bits.
   apq_ram #(
      .WIDTH (apq_pkg::ENTRY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_apq_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Unpack the request and the read data.
   assign req_tready = (state_ff == S_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign in_cmd     = req_tuser[0];
   assign in_value   = req_tdata[apq_pkg::VALUE_W-1:0];
   assign in_rank    = req_tdata[apq_pkg::ENTRY_W-1:apq_pkg::VALUE_W];
   assign rd_value   = rd_data[apq_pkg::VALUE_W-1:0];
   assign rd_rank    = rd_data[apq_pkg::ENTRY_W-1:apq_pkg::VALUE_W];

   // The rank comparator; strict less-than keeps the earliest entry on a tie.
   assign rank_less = (rd_rank < best_rank_ff);
   assign take_new  = pend_ff && ((pend_idx_ff == '0) || rank_less);
   assign issue     = (addr_ff < occ_ff);
   assign out_free  = !rsp_valid_ff || rsp_tready;

   // Sequencer next-state logic.
   always_comb begin
      state_in      = state_ff;
      occ_in        = occ_ff;
      addr_in       = addr_ff;
      pend_in       = 1'b0;
      pend_idx_in   = pend_idx_ff;
      best_idx_in   = best_idx_ff;
      best_value_in = best_value_ff;
      best_rank_in  = best_rank_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_rank_in   = rsp_rank_ff;
      rsp_fill_in   = rsp_fill_ff;
      wr_en         = 1'b0;
      wr_addr       = pend_idx_ff - 1'b1;
      wr_data       = rd_data;
      rd_en         = 1'b0;
      rd_addr       = addr_ff[IDX_W-1:0];

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               if (in_cmd == apq_pkg::CMD_ENQUEUE) begin
                  state_in = S_FINISH;
                  if (occ_ff == DEPTH_CNT) begin
                     res_status_in = apq_pkg::STATUS_FULL;
                  end else begin
                     wr_en         = 1'b1;
                     wr_addr       = occ_ff[IDX_W-1:0];
                     wr_data       = {in_rank, in_value};
                     occ_in        = occ_ff + 1'b1;
                     res_status_in = apq_pkg::STATUS_ENQUEUED;
                  end
               end else if (occ_ff == '0) begin
                  state_in      = S_FINISH;
                  res_status_in = apq_pkg::STATUS_EMPTY;
               end else begin
                  state_in      = S_SCAN;
                  addr_in       = '0;
                  res_status_in = apq_pkg::STATUS_DEQUEUED;
               end
            end
         end

         // Read every held entry in order and keep the smallest rank seen.
         S_SCAN: begin
            if (take_new) begin
               best_idx_in   = pend_idx_ff;
               best_value_in = rd_value;
               best_rank_in  = rd_rank;
            end
            if (issue) begin
               rd_en       = 1'b1;
               pend_in     = 1'b1;
               pend_idx_in = addr_ff[IDX_W-1:0];
               addr_in     = addr_ff + 1'b1;
            end else begin
               state_in = S_SHIFT;
               addr_in  = CNT_W'(best_idx_in) + 1'b1;
            end
         end

         // Move each later entry down one place to close the gap.
         S_SHIFT: begin
            if (pend_ff) begin
               wr_en = 1'b1;
            end
            if (issue) begin
               rd_en       = 1'b1;
               pend_in     = 1'b1;
               pend_idx_in = addr_ff[IDX_W-1:0];
               addr_in     = addr_ff + 1'b1;
            end else begin
               state_in = S_FINISH;
               occ_in   = occ_ff - 1'b1;
            end
         end

         // Load the output register once it is free.
         S_FINISH: begin
            if (out_free) begin
               state_in      = S_IDLE;
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_fill_in   = apq_pkg::FILL_W'(occ_ff);
               if (res_status_ff == apq_pkg::STATUS_DEQUEUED) begin
                  rsp_value_in = best_value_ff;
                  rsp_rank_in  = best_rank_ff;
               end else begin
                  rsp_value_in = '0;
                  rsp_rank_in  = '0;
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State, counters and the output register.
   always_ff @(posedge clock) begin
      addr_ff       <= addr_in;
      pend_idx_ff   <= pend_idx_in;
      best_idx_ff   <= best_idx_in;
      best_value_ff <= best_value_in;
      best_rank_ff  <= best_rank_in;
      res_status_ff <= res_status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_rank_ff   <= rsp_rank_in;
      rsp_fill_ff   <= rsp_fill_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         occ_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         occ_ff       <= occ_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {{apq_pkg::RSP_PAD_W{1'b0}}, rsp_fill_ff, rsp_rank_ff, rsp_value_ff};

endmodule

### rtl/apq_checker.sv
// Port-level checks for the priority queue.
module apq_checker #(
   parameter int QUEUE_DEPTH = 16
) (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [apq_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   input logic [apq_pkg::STATUS_W-1:0]     rsp_tuser
);

   localparam logic [apq_pkg::FILL_W-1:0] DEPTH_FILL = apq_pkg::FILL_W'(QUEUE_DEPTH);

   logic [apq_pkg::VALUE_W-1:0] rsp_value;
   logic [apq_pkg::RANK_W-1:0]  rsp_rank;
   logic [apq_pkg::FILL_W-1:0]  rsp_fill;

   assign rsp_value = rsp_tdata[apq_pkg::VALUE_W-1:0];
   assign rsp_rank  = rsp_tdata[apq_pkg::ENTRY_W-1:apq_pkg::VALUE_W];
   assign rsp_fill  = rsp_tdata[apq_pkg::ENTRY_W+apq_pkg::FILL_W-1:apq_pkg::ENTRY_W];

   // A stalled result item holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result item changed while stalled");

   // The queue works on one item at a time.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while an item is in progress");

   // An empty report carries no entry and an empty queue.
   a_empty_result: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == apq_pkg::STATUS_EMPTY
      |-> rsp_value == '0 && rsp_rank == '0 && rsp_fill == '0)
      else $error("empty result with nonzero fields");

   // A dropped item is reported only when the queue is at capacity.
   a_full_result: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == apq_pkg::STATUS_FULL
      |-> rsp_fill == DEPTH_FILL && rsp_value == '0 && rsp_rank == '0)
      else $error("full result below capacity");

   // The fill level never exceeds the queue depth.
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (QUEUE_DEPTH > 31) || (32'(rsp_fill) <= 32'(QUEUE_DEPTH)))
      else $error("fill level beyond queue depth");

endmodule

bind array_min_priority_queue apq_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_apq_checker (.*);

### tb/sv/tb.sv
module tb;

   localparam int          QUEUE_DEPTH  = 16;
   localparam int unsigned RANDOM_ITEMS = 1900;
   localparam int unsigned CYCLE_LIMIT  = 600000;
   localparam int unsigned DRAIN_CYCLES = 100;
   localparam int unsigned HOLD_OFF     = 400;
   localparam int unsigned PRINT_CAP    = 100;

   logic                              clock;
   logic                              reset;
   logic                              req_tvalid;
   logic                              req_tready;
   // [31:0] item_value, [47:32] item_rank
   logic [apq_pkg::REQ_TDATA_W-1:0]   req_tdata;
   // [0] command
   logic [0:0]                        req_tuser;
   logic                              rsp_tvalid;
   logic                              rsp_tready;
   // [31:0] removed_value, [47:32] removed_rank, [52:48] fill_level, [55:53] zero
   logic [apq_pkg::RSP_TDATA_W-1:0]   rsp_tdata;
   // [1:0] status
   logic [apq_pkg::STATUS_W-1:0]      rsp_tuser;

   int unsigned                       cycle_count;

   // One result item as the queue should return it.
   typedef struct packed {
      logic [apq_pkg::STATUS_W-1:0]  status;
      logic [apq_pkg::VALUE_W-1:0]   value;
      logic [apq_pkg::RANK_W-1:0]    rank;
      logic [apq_pkg::FILL_W-1:0]    fill;
   } queue_result_type;

   // Shadow copy of the queue contents and the results still owed by the block.
   class queue_scoreboard;
      logic [apq_pkg::VALUE_W-1:0]  held_values[QUEUE_DEPTH];
      logic [apq_pkg::RANK_W-1:0]   held_ranks[QUEUE_DEPTH];
      int unsigned                  held_count;
      queue_result_type             owed_results[$];
      int unsigned                  error_count;

      function new();
         held_count  = 0;
         error_count = 0;
      endfunction

      // Apply one accepted request to the shadow queue and note its result.
      function void note_request(logic cmd, logic [apq_pkg::VALUE_W-1:0] value,
                                 logic [apq_pkg::RANK_W-1:0] rank);
         queue_result_type outcome;
         int unsigned      best;
         outcome = '0;
         if (cmd == apq_pkg::CMD_ENQUEUE) begin
            if (held_count >= QUEUE_DEPTH) begin
               outcome.status = apq_pkg::STATUS_FULL;
            end else begin
               held_values[held_count] = value;
               held_ranks[held_count]  = rank;
               held_count++;
               outcome.status = apq_pkg::STATUS_ENQUEUED;
            end
         end else if (held_count == 0) begin
            outcome.status = apq_pkg::STATUS_EMPTY;
         end else begin
            // A strict comparison keeps the earliest arrival on equal ranks.
            best = 0;
            for (int unsigned i = 1; i < held_count; i++) begin
               if (held_ranks[i] < held_ranks[best])
                  best = i;
            end
            outcome.status = apq_pkg::STATUS_DEQUEUED;
            outcome.value  = held_values[best];
            outcome.rank   = held_ranks[best];
            // Close the gap left by the removed entry.
            for (int unsigned i = best; i + 1 < held_count; i++) begin
               held_values[i] = held_values[i + 1];
               held_ranks[i]  = held_ranks[i + 1];
            end
            held_count--;
         end
         outcome.fill = apq_pkg::FILL_W'(held_count);
         owed_results.push_back(outcome);
      endfunction

      task report_mismatch(string what);
         if (error_count < PRINT_CAP)
            $display("ERROR at %0t: %s", $time, what);
         error_count++;
      endtask

      // Compare one accepted result item with the oldest owed result.
      task check_result(logic [apq_pkg::STATUS_W-1:0] status,
                        logic [apq_pkg::RSP_TDATA_W-1:0] data);
         queue_result_type               owed;
         logic [apq_pkg::VALUE_W-1:0]    got_value;
         logic [apq_pkg::RANK_W-1:0]     got_rank;
         logic [apq_pkg::FILL_W-1:0]     got_fill;
         logic [apq_pkg::RSP_PAD_W-1:0]  got_pad;
         got_value = data[apq_pkg::VALUE_W-1:0];
         got_rank  = data[apq_pkg::VALUE_W +: apq_pkg::RANK_W];
         got_fill  = data[apq_pkg::VALUE_W+apq_pkg::RANK_W +: apq_pkg::FILL_W];
         got_pad   = data[apq_pkg::RSP_TDATA_W-1 -: apq_pkg::RSP_PAD_W];
         if (owed_results.size() == 0) begin
            report_mismatch($sformatf("result item with none owed, status %0d", status));
         end else begin
            owed = owed_results.pop_front();
            if (status !== owed.status)
               report_mismatch($sformatf("status %0d, expected %0d", status, owed.status));
            if (got_value !== owed.value)
               report_mismatch($sformatf("removed_value %h, expected %h",
                                         got_value, owed.value));
            if (got_rank !== owed.rank)
               report_mismatch($sformatf("removed_rank %h, expected %h",
                                         got_rank, owed.rank));
            if (got_fill !== owed.fill)
               report_mismatch($sformatf("fill_level %0d, expected %0d",
                                         got_fill, owed.fill));
            if (got_pad !== '0)
               report_mismatch($sformatf("pad bits %b, expected zero", got_pad));
         end
      endtask
   endclass

   queue_scoreboard sb;

   array_min_priority_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Offer one item from a falling edge and wait for the edge that takes it.
   // The valid is left high so that a burst runs on without a gap.
   task automatic send_item(logic cmd, logic [apq_pkg::VALUE_W-1:0] value,
                            logic [apq_pkg::RANK_W-1:0] rank);
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {rank, value};
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      sb.note_request(cmd, value, rank);
      @(negedge clock);
   endtask

   task automatic idle_gap(int unsigned cycles);
      if (cycles > 0) begin
         req_tvalid <= 1'b0;
         repeat (cycles) @(negedge clock);
      end
   endtask

   // Extremes, ties, a full queue, drops and a dequeue from an empty queue.
   task automatic drive_directed_items();
      send_item(apq_pkg::CMD_DEQUEUE, $urandom, 16'($urandom));
      send_item(apq_pkg::CMD_ENQUEUE, 32'h8000_0000, 16'hFFFF);
      send_item(apq_pkg::CMD_ENQUEUE, 32'h7FFF_FFFF, 16'h0000);
      send_item(apq_pkg::CMD_ENQUEUE, 32'h0000_0000, 16'd100);
      send_item(apq_pkg::CMD_ENQUEUE, 32'hFFFF_FFFF, 16'd100);
      idle_gap(3);
      send_item(apq_pkg::CMD_ENQUEUE, 32'h0000_0001, 16'd100);
      send_item(apq_pkg::CMD_ENQUEUE, 32'h5555_AAAA, 16'h0000);
      send_item(apq_pkg::CMD_ENQUEUE, 32'hAAAA_5555, 16'hFFFF);
      for (int i = 0; i < 9; i++)
         send_item(apq_pkg::CMD_ENQUEUE, $urandom, 16'($urandom_range(0, 7)));
      // The queue is now full, so these two are dropped.
      send_item(apq_pkg::CMD_ENQUEUE, 32'hDEAD_0001, 16'h0000);
      send_item(apq_pkg::CMD_ENQUEUE, 32'hDEAD_0002, 16'h0000);
      for (int i = 0; i < 6; i++)
         send_item(apq_pkg::CMD_DEQUEUE, $urandom, 16'($urandom));
   endtask

   // Random traffic in segments that lean towards filling or draining the queue,
   // some with narrow rank ranges so that ties are common.
   task automatic drive_random_items(int unsigned count);
      int unsigned sent       = 0;
      int unsigned burst_left = 0;
      int unsigned enq_pct    = 50;
      int unsigned rank_span  = 16'hFFFF;
      logic        cmd;
      while (sent < count) begin
         if (sent % 100 == 0) begin
            case ($urandom_range(0, 2))
               0: enq_pct = 25;
               1: enq_pct = 50;
               default: enq_pct = 75;
            endcase
            case ($urandom_range(0, 2))
               0: rank_span = 3;
               1: rank_span = 255;
               default: rank_span = 16'hFFFF;
            endcase
         end
         if (burst_left == 0) begin
            idle_gap(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
            burst_left = $urandom_range(1, 24);
         end
         cmd = ($urandom_range(0, 99) < enq_pct) ? apq_pkg::CMD_ENQUEUE
                                                  : apq_pkg::CMD_DEQUEUE;
         send_item(cmd, $urandom, 16'($urandom_range(0, rank_span)));
         burst_left--;
         sent++;
      end
   endtask

   // Receiver stalls on its own pattern, with one long hold-off to back the block up.
   initial begin : rsp_stall_pattern
      int unsigned round;
      int unsigned mode;
      int unsigned span;
      rsp_tready = 1'b0;
      round = 0;
      @(negedge reset);
      forever begin
         round++;
         if (round == 6) begin
            @(negedge clock);
            rsp_tready <= 1'b0;
            repeat (HOLD_OFF - 1) @(negedge clock);
         end else begin
            mode = $urandom_range(0, 9);
            span = $urandom_range(10, 120);
            repeat (span) begin
               @(negedge clock);
               if (mode < 4)
                  rsp_tready <= 1'b1;
               else if (mode < 8)
                  rsp_tready <= $urandom_range(0, 1);
               else
                  rsp_tready <= ($urandom_range(0, 3) == 0);
            end
         end
      end
   end

   // Check every result item taken at a rising edge.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_result(rsp_tuser, rsp_tdata);
   end

   // Watchdog on the whole run.
   initial begin : watchdog
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Simulation FAILED");
      $finish;
   end

   // Reset, stimulus, then drain and verdict.
   initial begin : main_sequence
      sb         = new();
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = apq_pkg::CMD_ENQUEUE;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      drive_directed_items();
      drive_random_items(RANDOM_ITEMS);
      req_tvalid <= 1'b0;
      while (sb.owed_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.error_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
